// ===== design/bpe_pkg.sv =====
// Shared definitions for the Bezier point evaluator.
// Default parameter values, control point count and configuration register indexes.
// No dependencies.
package bpe_pkg;

  localparam int DEGREE_DEF      = 3;
  localparam int COORD_BITS_DEF  = 12;
  localparam int T_FRAC_BITS_DEF = 16;

  // Control points p0..p3; higher degrees are not supported
  localparam int NUM_PTS   = 4;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_P0_X = 3'd0;
  localparam cfg_idx_t REG_P0_Y = 3'd1;
  localparam cfg_idx_t REG_P1_X = 3'd2;
  localparam cfg_idx_t REG_P1_Y = 3'd3;
  localparam cfg_idx_t REG_P2_X = 3'd4;
  localparam cfg_idx_t REG_P2_Y = 3'd5;
  localparam cfg_idx_t REG_P3_X = 3'd6;
  localparam cfg_idx_t REG_P3_Y = 3'd7;

endpackage

// ===== design/bpe_in_if.sv =====
// Valid/ready channel carrying the curve parameter into the evaluator.
// Default width taken from bpe_pkg.
interface bpe_in_if #(
  parameter int T_W = bpe_pkg::T_FRAC_BITS_DEF + 1
) ();
  logic           valid;
  logic           ready;
  logic [T_W-1:0] t_param;

  modport source (output valid, output t_param, input ready);
  modport sink   (input valid, input t_param, output ready);
endinterface

// ===== design/bpe_out_if.sv =====
// Valid/ready channel carrying the evaluated curve point out of the evaluator.
// Default width taken from bpe_pkg.
interface bpe_out_if #(
  parameter int C_W = bpe_pkg::COORD_BITS_DEF
) ();
  logic           valid;
  logic           ready;
  logic [C_W-1:0] curve_x;
  logic [C_W-1:0] curve_y;

  modport source (output valid, output curve_x, output curve_y, input ready);
  modport sink   (input valid, input curve_x, input curve_y, output ready);
endinterface

// ===== design/bpe_weight_gen.sv =====
// Bernstein weight generator: clamp, power and weight stages (three register stages).
// Depends on bpe_pkg.
module bpe_weight_gen #(
  parameter int DEGREE      = bpe_pkg::DEGREE_DEF,
  parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [T_FRAC_BITS:0]                          in_t,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [bpe_pkg::NUM_PTS-1:0][T_FRAC_BITS:0]    out_w
);
  import bpe_pkg::*;

  localparam int TW      = T_FRAC_BITS + 1;
  localparam int EFF_DEG = (DEGREE < 1) ? 1 : ((DEGREE > 3) ? 3 : DEGREE);
  localparam logic [TW-1:0] ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  // Q1.T product, truncated
  function automatic logic [TW-1:0] qmul(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [2*TW-1:0] p;
    p = {{TW{1'b0}}, a} * {{TW{1'b0}}, b};
    return p[T_FRAC_BITS +: TW];
  endfunction

  function automatic logic [TW-1:0] times2(input logic [TW-1:0] m);
    return {m[TW-2:0], 1'b0};
  endfunction

  function automatic logic [TW-1:0] times3(input logic [TW-1:0] m);
    logic [TW+1:0] x;
    x = {2'b00, m} + {1'b0, m, 1'b0};
    return x[TW-1:0];
  endfunction

  logic                 va_r, vb_r, vc_r;
  logic                 rdy_a, rdy_b, rdy_c;
  logic [TW-1:0]        tv_a_r, sv_a_r, tv_a_nxt, sv_a_nxt;
  logic [TW-1:0]        tv_b_r, sv_b_r, tt_b_r, ss_b_r, st_b_r;
  logic [TW-1:0]        tt_b_nxt, ss_b_nxt, st_b_nxt;
  logic [TW-1:0]        ttt, sss, sst, stt;
  logic [NUM_PTS-1:0][TW-1:0] w_c_r, w_c_nxt;

  // Stage advances when empty or when the next stage advances
  assign rdy_c    = !vc_r || out_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    tv_a_nxt = (in_t > ONE) ? ONE : in_t;
    sv_a_nxt = ONE - tv_a_nxt;
  end

  always_comb begin
    tt_b_nxt = qmul(tv_a_r, tv_a_r);
    ss_b_nxt = qmul(sv_a_r, sv_a_r);
    st_b_nxt = qmul(sv_a_r, tv_a_r);
  end

  always_comb begin
    ttt = qmul(tt_b_r, tv_b_r);
    sss = qmul(ss_b_r, sv_b_r);
    sst = qmul(ss_b_r, tv_b_r);
    stt = qmul(sv_b_r, tt_b_r);
    w_c_nxt = '0;
    if (EFF_DEG == 1) begin
      w_c_nxt[0] = sv_b_r;
      w_c_nxt[1] = tv_b_r;
    end else if (EFF_DEG == 2) begin
      w_c_nxt[0] = ss_b_r;
      w_c_nxt[1] = times2(st_b_r);
      w_c_nxt[2] = tt_b_r;
    end else begin
      w_c_nxt[0] = sss;
      w_c_nxt[1] = times3(sst);
      w_c_nxt[2] = times3(stt);
      w_c_nxt[3] = ttt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      tv_a_r <= tv_a_nxt;
      sv_a_r <= sv_a_nxt;
    end
    if (rdy_b) begin
      tv_b_r <= tv_a_r;
      sv_b_r <= sv_a_r;
      tt_b_r <= tt_b_nxt;
      ss_b_r <= ss_b_nxt;
      st_b_r <= st_b_nxt;
    end
    if (rdy_c) begin
      w_c_r <= w_c_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_w     = w_c_r;

endmodule

// ===== design/bpe_blend.sv =====
// Weighted sum of control coordinates: multiply, pair add and final add stages.
// Depends on bpe_pkg.
module bpe_blend #(
  parameter int COORD_BITS  = bpe_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [bpe_pkg::NUM_PTS-1:0][T_FRAC_BITS:0]  in_w,
  input  logic [bpe_pkg::NUM_PTS-1:0][COORD_BITS-1:0] px,
  input  logic [bpe_pkg::NUM_PTS-1:0][COORD_BITS-1:0] py,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [COORD_BITS-1:0]                       out_x,
  output logic [COORD_BITS-1:0]                       out_y
);
  import bpe_pkg::*;

  localparam int TW = T_FRAC_BITS + 1;
  localparam int PW = COORD_BITS + TW;

  logic vd_r, ve_r, vf_r;
  logic rdy_d, rdy_e, rdy_f;
  logic [NUM_PTS-1:0][PW-1:0] prod_x_r, prod_y_r, prod_x_nxt, prod_y_nxt;
  logic [1:0][PW:0]           pair_x_r, pair_y_r, pair_x_nxt, pair_y_nxt;
  logic [PW+1:0]              sum_x, sum_y;
  logic [COORD_BITS-1:0]      x_f_r, y_f_r;

  assign rdy_f    = !vf_r || out_ready;
  assign rdy_e    = !ve_r || rdy_f;
  assign rdy_d    = !vd_r || rdy_e;
  assign in_ready = rdy_d;

  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      prod_x_nxt[i] = PW'(px[i]) * PW'(in_w[i]);
      prod_y_nxt[i] = PW'(py[i]) * PW'(in_w[i]);
    end
    for (int j = 0; j < 2; j++) begin
      pair_x_nxt[j] = {1'b0, prod_x_r[2*j]} + {1'b0, prod_x_r[2*j+1]};
      pair_y_nxt[j] = {1'b0, prod_y_r[2*j]} + {1'b0, prod_y_r[2*j+1]};
    end
    sum_x = {1'b0, pair_x_r[0]} + {1'b0, pair_x_r[1]};
    sum_y = {1'b0, pair_y_r[0]} + {1'b0, pair_y_r[1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (rdy_d) vd_r <= in_valid;
      if (rdy_e) ve_r <= vd_r;
      if (rdy_f) vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
    end
    if (rdy_e) begin
      pair_x_r <= pair_x_nxt;
      pair_y_r <= pair_y_nxt;
    end
    // Drop the fraction once, after the full sum
    if (rdy_f) begin
      x_f_r <= sum_x[T_FRAC_BITS +: COORD_BITS];
      y_f_r <= sum_y[T_FRAC_BITS +: COORD_BITS];
    end
  end

  assign out_valid = vf_r;
  assign out_x     = x_f_r;
  assign out_y     = y_f_r;

endmodule

// ===== design/bezier_point_evaluator.sv =====
// Cubic (or lower degree) Bezier point evaluator, top level.
// Depends on bpe_pkg, bpe_in_if, bpe_out_if, bpe_weight_gen and bpe_blend.
//
// Each transaction on in_ch carries a curve parameter t (1 << T_FRAC_BITS is 1.0; larger
// values are taken as 1.0) and yields exactly one transaction on out_ch holding the curve
// point over the control points p0..pDEGREE, truncated to whole pixels. The block takes
// one transaction per cycle while out_ch is not stalled and returns results in order
// through six register stages. Three stages form the Bernstein weights (clamp, squares,
// cubes and weights), three form the blended coordinates (products, pair sums, final
// sum). Every stage holds when the stage after it is full and stalled, so back-pressure
// on out_ch fills the pipeline's bubbles before in_ch.ready drops; nothing is lost or
// repeated. Write the control point registers through cfg_we/cfg_index/cfg_wdata only
// while no transaction is in flight; they reset to zero.
module bezier_point_evaluator #(
  parameter int DEGREE      = bpe_pkg::DEGREE_DEF,
  parameter int COORD_BITS  = bpe_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bpe_in_if.sink                        in_ch,
  bpe_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  bpe_pkg::cfg_idx_t             cfg_index,
  input  logic [COORD_BITS-1:0]         cfg_wdata
);
  import bpe_pkg::*;

  localparam int TW = T_FRAC_BITS + 1;
  localparam logic [TW+1:0] ONE_EXT = {3'b001, {T_FRAC_BITS{1'b0}}};

  // Control point registers
  logic [NUM_PTS-1:0][COORD_BITS-1:0] px_r, py_r;

  logic                       wg_valid, wg_ready;
  logic [NUM_PTS-1:0][TW-1:0] wg_w;
  logic [TW+1:0]              w_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_P0_X: px_r[0] <= cfg_wdata;
        REG_P0_Y: py_r[0] <= cfg_wdata;
        REG_P1_X: px_r[1] <= cfg_wdata;
        REG_P1_Y: py_r[1] <= cfg_wdata;
        REG_P2_X: px_r[2] <= cfg_wdata;
        REG_P2_Y: py_r[2] <= cfg_wdata;
        REG_P3_X: px_r[3] <= cfg_wdata;
        REG_P3_Y: py_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Weights: clamp t, form powers of t and 1-t, scale by binomial coefficients
  bpe_weight_gen #(
    .DEGREE      (DEGREE),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_weight_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_t      (in_ch.t_param),
    .out_valid (wg_valid),
    .out_ready (wg_ready),
    .out_w     (wg_w)
  );

  // Blend: weight each control coordinate, sum, truncate to pixels
  bpe_blend #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wg_valid),
    .in_ready  (wg_ready),
    .in_w      (wg_w),
    .px        (px_r),
    .py        (py_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.curve_x),
    .out_y     (out_ch.curve_y)
  );

  assign w_sum = {2'b00, wg_w[0]} + {2'b00, wg_w[1]} + {2'b00, wg_w[2]} + {2'b00, wg_w[3]};

  // Truncated weights never add up to more than one, so the sum cannot overflow
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    wg_valid |-> (w_sum <= ONE_EXT))
    else $error("weight sum above one");

  // A free output must leave every stage able to advance
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output is free");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

// ===== test/bezier_point_evaluator_tb.sv =====
// Self-checking testbench for bezier_point_evaluator: streams curve parameters under
// several control point settings and checks every curve point against a local predictor.
// Depends on bpe_pkg, bpe_in_if, bpe_out_if and the evaluator RTL.
module bezier_point_evaluator_tb;
  import bpe_pkg::*;

  localparam int T_W   = T_FRAC_BITS_DEF + 1;
  localparam int C_W   = COORD_BITS_DEF;
  localparam int N_REG = 2 * NUM_PTS;
  // Clamp the degree the same way the block does
  localparam int EFF_DEG = (DEGREE_DEF < 1) ? 1 : ((DEGREE_DEF > 3) ? 3 : DEGREE_DEF);
  localparam logic [63:0] T_ONE = 64'd1 << T_FRAC_BITS_DEF;

  localparam int PIPE_LAT     = 6;
  localparam int DRAIN_CYCLES = 4 * PIPE_LAT;
  localparam int LONG_HOLD    = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PER_SET = 280;

  typedef struct packed {
    logic [C_W-1:0] x;
    logic [C_W-1:0] y;
  } curve_pt_t;

  logic clk;
  logic rst_n;
  logic           cfg_we;
  cfg_idx_t       cfg_index;
  logic [C_W-1:0] cfg_wdata;

  bpe_in_if  #(.T_W(T_W)) in_ch  ();
  bpe_out_if #(.C_W(C_W)) out_ch ();

  bezier_point_evaluator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the control point registers, indexed by register index
  logic [C_W-1:0] ctrl_reg [N_REG];

  logic [T_W-1:0] pending_t [$];  // parameters waiting to be offered
  curve_pt_t      point_q   [$];  // curve points still owed by the block

  int  n_queued;
  int  n_received;
  int  n_checked;
  int  n_settings;
  int  err_cnt;
  int  src_gap;
  int  sink_gap;
  int  cycle_cnt;
  int  hold_left;
  bit  idle_en;
  bit  hold_req;

  // Clock: period of 4 units
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bernstein evaluation at the block's widths: clamp t, build truncated powers of t and
  // 1 - t, form truncated weights and sum the weighted coordinates at full precision.
  function automatic curve_pt_t bezier_point(input logic [T_W-1:0] t_in);
    logic [63:0] tv;
    logic [63:0] sv;
    logic [63:0] tp [4];
    logic [63:0] sp [4];
    logic [63:0] w;
    logic [63:0] binom;
    logic [63:0] acc_x;
    logic [63:0] acc_y;
    curve_pt_t   pt;
    tv = (64'(t_in) > T_ONE) ? T_ONE : 64'(t_in);
    sv = T_ONE - tv;
    tp[0] = T_ONE;
    sp[0] = T_ONE;
    for (int k = 1; k < 4; k++) begin
      tp[k] = (tp[k-1] * tv) >> T_FRAC_BITS_DEF;
      sp[k] = (sp[k-1] * sv) >> T_FRAC_BITS_DEF;
    end
    acc_x = '0;
    acc_y = '0;
    for (int i = 0; i <= EFF_DEG; i++) begin
      // C(n,i) for n up to 3 is 1 at the ends and n in between
      binom = (i == 0 || i == EFF_DEG) ? 64'd1 : 64'(EFF_DEG);
      w = binom * ((sp[EFF_DEG-i] * tp[i]) >> T_FRAC_BITS_DEF);
      acc_x += 64'(ctrl_reg[2*i]) * w;
      acc_y += 64'(ctrl_reg[2*i+1]) * w;
    end
    pt.x = C_W'(acc_x >> T_FRAC_BITS_DEF);
    pt.y = C_W'(acc_y >> T_FRAC_BITS_DEF);
    return pt;
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR: %s", msg);
  endtask

  // Write one register at a rising edge and mirror it in the shadow copy
  task automatic write_reg(input cfg_idx_t idx, input logic [C_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    ctrl_reg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_points(input logic [C_W-1:0] x0, input logic [C_W-1:0] y0,
                             input logic [C_W-1:0] x1, input logic [C_W-1:0] y1,
                             input logic [C_W-1:0] x2, input logic [C_W-1:0] y2,
                             input logic [C_W-1:0] x3, input logic [C_W-1:0] y3);
    write_reg(REG_P0_X, x0);
    write_reg(REG_P0_Y, y0);
    write_reg(REG_P1_X, x1);
    write_reg(REG_P1_Y, y1);
    write_reg(REG_P2_X, x2);
    write_reg(REG_P2_Y, y2);
    write_reg(REG_P3_X, x3);
    write_reg(REG_P3_Y, y3);
    n_settings++;
  endtask

  task automatic load_random_points();
    load_points(C_W'($urandom), C_W'($urandom), C_W'($urandom), C_W'($urandom),
                C_W'($urandom), C_W'($urandom), C_W'($urandom), C_W'($urandom));
  endtask

  // Queue a parameter for the driver; callers queue away from the clock edge
  task automatic queue_t(input logic [T_W-1:0] t_val);
    pending_t.push_back(t_val);
    n_queued++;
  endtask

  // Mostly in-range parameters, with endpoints, saturating values and raw 17-bit noise
  task automatic queue_random(input int n);
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       queue_t($urandom_range(0, 1) ? T_W'(T_ONE) : '0);
        1:       queue_t(T_W'($urandom_range(T_ONE + 1, (1 << T_W) - 1)));
        2:       queue_t(T_W'($urandom));
        3:       queue_t(T_W'($urandom_range(0, 255)));
        4:       queue_t(T_W'($urandom_range(T_ONE - 256, T_ONE)));
        default: queue_t(T_W'($urandom_range(0, T_ONE)));
      endcase
    end
  endtask

  // Hold until every queued parameter has come back as a point, then let the pipe settle
  task automatic wait_idle();
    while (n_received < n_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: record each accepted transaction's expected point, then offer the next
  // parameter or idle for a burst. valid is held while an offer waits for ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.t_param <= '0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) point_q.push_back(bezier_point(in_ch.t_param));
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_t.size() > 0) begin
          in_ch.valid   <= 1'b1;
          in_ch.t_param <= pending_t.pop_front();
          if (idle_en && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 6);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here on its own
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each point with the oldest expectation, then decide ready
  always @(posedge clk) begin
    curve_pt_t exp_pt;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_received++;
        if (point_q.size() == 0) begin
          flag_error($sformatf("unexpected point x=%0d y=%0d", out_ch.curve_x,
                               out_ch.curve_y));
        end else begin
          exp_pt = point_q.pop_front();
          n_checked++;
          if (out_ch.curve_x !== exp_pt.x || out_ch.curve_y !== exp_pt.y)
            flag_error($sformatf("point %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                                 n_checked, exp_pt.x, exp_pt.y, out_ch.curve_x,
                                 out_ch.curve_y));
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 6);
      end
    end
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d points outstanding", cycle_cnt,
               n_queued - n_received);
      $display("bezier_point_evaluator verification failed");
      $finish;
    end
  end

  // Stimulus sequence: reset, directed parameters, then random phases per setting
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.t_param = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_P0_X;
    cfg_wdata     = '0;
    hold_req      = 1'b0;
    idle_en       = 1'b1;
    n_queued      = 0;
    n_received    = 0;
    n_checked     = 0;
    n_settings    = 0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    for (int i = 0; i < N_REG; i++) ctrl_reg[i] = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: every point is the origin
    @(negedge clk);
    queue_t('0);
    queue_t(T_W'(T_ONE >> 1));
    queue_t(T_W'(T_ONE));
    queue_t('1);
    wait_idle();

    // Directed: distinct corners so each weight shows; endpoints, saturation, bit walk
    load_points(12'd0, 12'd4095, 12'd4095, 12'd0, 12'd100, 12'd3000, 12'd4095, 12'd4095);
    @(negedge clk);
    queue_t('0);                         // t = 0 returns p0 exactly
    queue_t(T_W'(1));
    queue_t(T_W'(T_ONE - 1));
    queue_t(T_W'(T_ONE));                // t = 1.0 returns p3 exactly
    queue_t(T_W'(T_ONE + 1));            // above one saturates to 1.0
    queue_t('1);
    queue_t(T_W'(T_ONE >> 1));
    queue_t(T_W'(T_ONE >> 2));
    queue_t(T_W'((T_ONE >> 1) + (T_ONE >> 2)));
    queue_t(T_W'(17'h05555));
    queue_t(T_W'(17'h0AAAA));
    queue_t(T_W'(17'h18000));
    for (int k = 2; k < T_W - 1; k += 2) queue_t(T_W'(1 << k));
    wait_idle();

    // All points at the far corner, with a long receiver hold-off while the sender
    // keeps offering, so the pipeline fills and in_ch.ready drops
    load_points('1, '1, '1, '1, '1, '1, '1, '1);
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    queue_random(RAND_PER_SET);
    wait_idle();

    load_random_points();
    queue_random(RAND_PER_SET);
    wait_idle();

    // Endpoints high, inner points at zero
    load_points('1, '1, '0, '0, '0, '0, '1, '1);
    queue_random(RAND_PER_SET);
    wait_idle();

    load_random_points();
    queue_random(RAND_PER_SET);
    wait_idle();

    // Endpoints at zero, inner points high
    load_points('0, '0, '1, '1, '1, '1, '0, '0);
    queue_random(RAND_PER_SET);
    wait_idle();

    // Final stretch at full rate on both sides
    idle_en = 1'b0;
    load_random_points();
    queue_random(RAND_PER_SET);
    wait_idle();

    while (point_q.size() > 0) begin
      flag_error($sformatf("point never produced x=%0d y=%0d", point_q[0].x,
                           point_q[0].y));
      void'(point_q.pop_front());
    end

    $display("Covered %0d curve parameters over %0d control point settings;",
             n_queued, n_settings + 1);
    $display("%0d points compared, %0d mismatches", n_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("bezier_point_evaluator verification clean");
    end else begin
      $display("bezier_point_evaluator verification failed");
    end
    $finish;
  end

endmodule
